@@ design/assert_macros.svh @@
// assertion macros for the reachability block checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/dgr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dgr_pkg;

	localparam int NODE_W       = 5;
	localparam int NODE_COUNT_W = 6;
	localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 6'd32;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_EDGE   = 2'd2;
	localparam logic [1:0] KIND_REACH  = 2'd3;

	localparam logic [2:0] STATUS_OK     = 3'd0;
	localparam logic [2:0] STATUS_RANGE  = 3'd1;
	localparam logic [2:0] STATUS_EXISTS = 3'd2;
	localparam logic [2:0] STATUS_ABSENT = 3'd3;
	localparam logic [2:0] STATUS_SELF   = 3'd4;

	typedef struct packed {
		logic [1:0]        kind;
		logic [NODE_W-1:0] src_node;
		logic [NODE_W-1:0] dst_node;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       found;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic edge_op;
		logic step;
		logic reach_done;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic item_bad;
		logic item_reach;
		logic sweep_done;
	} stat_t;

endpackage

`default_nettype wire

@@ design/directed_graph_reachability_unit.sv @@
// one request in flight; a request with a vertex out of range goes straight to the result,
// an edge add, remove or test first reads the source row (add and remove may rewrite it), and a
// reachability test first fetches adjacency rows: the source's row, then the row of every newly
// reached vertex, lowest pending first, until none is pending (at most MAX_NODES + 1 rows in all)
// a result waits while a stalled one holds the output register; the next request is taken once the result sits there
// reset (async, active low) empties the graph through per-row valid bits and sets node_count to 32
`timescale 1ns / 1ps
`default_nettype none

module directed_graph_reachability_unit #(
	parameter int MAX_NODES = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [dgr_pkg::NODE_COUNT_W-1:0] cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire dgr_pkg::item_t                   in_item,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output dgr_pkg::result_t                      out_item
);

	dgr_pkg::cmd_t  cmd;
	dgr_pkg::stat_t stat;

	dgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dgr_datapath #(
		.MAX_NODES(MAX_NODES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_item (in_item),
		.cmd     (cmd),
		.stat    (stat),
		.out_item(out_item)
	);

endmodule

`default_nettype wire

@@ design/dgr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/dgr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dgr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire dgr_pkg::stat_t stat,
	output dgr_pkg::cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.take       = accept;
		cmd.edge_op    = (state_q == ST_EDGE);
		cmd.step       = (state_q == ST_SWEEP);
		cmd.reach_done = (state_q == ST_SWEEP) && stat.sweep_done;
		cmd.load_out   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (stat.item_bad) begin
							state_q <= ST_DONE;
						end else if (stat.item_reach) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_EDGE;
						end
					end
				end
				ST_EDGE: begin
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					if (stat.sweep_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/dgr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dgr_datapath #(
	parameter int MAX_NODES = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [dgr_pkg::NODE_COUNT_W-1:0]    cfg_data,
	input  wire dgr_pkg::item_t                      in_item,
	input  wire dgr_pkg::cmd_t                       cmd,
	output dgr_pkg::stat_t                           stat,
	output dgr_pkg::result_t                         out_item
);

	localparam int N  = MAX_NODES;
	localparam int AW = $clog2(N);

	logic [dgr_pkg::NODE_COUNT_W-1:0] ncount_q;
	dgr_pkg::item_t   item_q;
	dgr_pkg::result_t res_q;
	dgr_pkg::result_t out_item_q;

	logic [N-1:0]  row_valid_q;
	logic          row_valid_s1;
	logic [N-1:0]  visited_q;
	logic [N-1:0]  pending_q;
	logic          inflight_q;

	logic [N-1:0]  vmask;
	logic [N-1:0]  rdata;
	logic [N-1:0]  row_w;
	logic [N-1:0]  new_w;
	logic [N-1:0]  low_oh;
	logic [AW-1:0] pick_idx;
	logic [AW-1:0] raddr;
	logic [AW-1:0] src_a;
	logic [AW-1:0] dst_a;
	logic [N-1:0]  dbit;
	logic          has_edge;
	logic          src_ok;
	logic          dst_ok;

	logic          wr_en;
	logic [N-1:0]  wr_row;
	dgr_pkg::result_t edge_res;

	// vertices below the effective count take part in the search
	always_comb begin
		for (int i = 0; i < N; i++) begin
			vmask[i] = (9'(i) < {3'b000, ncount_q});
		end
	end

	assign src_ok = (9'(in_item.src_node) < {3'b000, ncount_q}) &&
	                (9'(in_item.src_node) < 9'(N));
	assign dst_ok = (9'(in_item.dst_node) < {3'b000, ncount_q}) &&
	                (9'(in_item.dst_node) < 9'(N));

	assign stat.item_bad   = !(src_ok && dst_ok);
	assign stat.item_reach = (in_item.kind == dgr_pkg::KIND_REACH);
	assign stat.sweep_done = !inflight_q && (pending_q == '0);

	assign src_a = AW'(item_q.src_node);
	assign dst_a = AW'(item_q.dst_node);
	assign dbit  = N'(1) << dst_a;

	// never-written rows read as empty
	assign row_w    = row_valid_s1 ? rdata : '0;
	assign new_w    = row_w & vmask & ~visited_q;
	assign has_edge = row_w[dst_a];

	// lowest pending vertex is the next row to fetch
	assign low_oh = pending_q & (~pending_q + N'(1));
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (low_oh[i]) begin
				pick_idx = pick_idx | AW'(i);
			end
		end
	end

	assign raddr = cmd.take ? AW'(in_item.src_node) : pick_idx;

	always_comb begin
		wr_en    = 1'b0;
		wr_row   = row_w;
		edge_res = '{status: dgr_pkg::STATUS_OK, found: 1'b0};
		case (item_q.kind)
			dgr_pkg::KIND_ADD: begin
				if (has_edge) begin
					edge_res.status = dgr_pkg::STATUS_EXISTS;
				end else if (item_q.src_node == item_q.dst_node) begin
					edge_res.status = dgr_pkg::STATUS_SELF;
				end else begin
					wr_en  = 1'b1;
					wr_row = row_w | dbit;
				end
			end
			dgr_pkg::KIND_REMOVE: begin
				if (!has_edge) begin
					edge_res.status = dgr_pkg::STATUS_ABSENT;
				end else begin
					wr_en  = 1'b1;
					wr_row = row_w & ~dbit;
				end
			end
			dgr_pkg::KIND_EDGE: begin
				edge_res.found = has_edge;
			end
			default: begin
				edge_res = '{status: dgr_pkg::STATUS_OK, found: 1'b0};
			end
		endcase
	end

	dgr_ram #(
		.WIDTH(N),
		.DEPTH(N)
	) u_adj_ram (
		.clk  (clk),
		.we   (cmd.edge_op && wr_en),
		.waddr(src_a),
		.wdata(wr_row),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q     <= dgr_pkg::NODE_COUNT_RESET;
			row_valid_q  <= '0;
			row_valid_s1 <= 1'b0;
			visited_q    <= '0;
			pending_q    <= '0;
			inflight_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				ncount_q <= cfg_data;
			end
			row_valid_s1 <= row_valid_q[raddr];
			if (cmd.edge_op && wr_en) begin
				row_valid_q[src_a] <= 1'b1;
			end
			if (cmd.take) begin
				visited_q  <= '0;
				pending_q  <= '0;
				inflight_q <= 1'b1;
			end else if (cmd.step) begin
				inflight_q <= (pending_q != '0);
				if (inflight_q) begin
					visited_q <= visited_q | new_w;
					pending_q <= (pending_q & ~low_oh) | new_w;
				end else begin
					pending_q <= pending_q & ~low_oh;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= in_item;
			res_q  <= '{status: dgr_pkg::STATUS_RANGE, found: 1'b0};
		end else if (cmd.edge_op) begin
			res_q <= edge_res;
		end else if (cmd.reach_done) begin
			res_q <= '{status: dgr_pkg::STATUS_OK, found: visited_q[dst_a]};
		end
		if (cmd.load_out) begin
			out_item_q <= res_q;
		end
	end

	assign out_item = out_item_q;

endmodule

`default_nettype wire

@@ design/dgr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dgr_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire dgr_pkg::result_t out_item
);

	// a stalled result holds
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")

	// one request at a time: stall rises right after a request is taken
	`ASSERT_CLK(a_one_in_flight, clk, arst_n, in_valid && !in_stall |=> in_stall, "second request taken while busy")

	// status codes stay within the defined set
	`ASSERT_NEVER(a_status_code, clk, arst_n, out_valid && (out_item.status > dgr_pkg::STATUS_SELF), "undefined status code")

	// found is only reported alongside an ok status
	`ASSERT_NEVER(a_found_ok, clk, arst_n, out_valid && out_item.found && (out_item.status != dgr_pkg::STATUS_OK), "found with error status")

endmodule

bind directed_graph_reachability_unit dgr_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item (out_item)
);

`default_nettype wire

@@ test/tb_directed_graph_reachability_unit.sv @@
`timescale 1ns / 1ps

module tb_directed_graph_reachability_unit;

	localparam int NODES = 32;
	localparam int DIR_ROWS = 25;
	localparam int SEG_ITEMS = 140;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [dgr_pkg::NODE_COUNT_W-1:0] cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	dgr_pkg::item_t                   in_item = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	dgr_pkg::result_t                 out_item;

	// own copy of the graph and the vertex count
	logic [NODES-1:0]                 edge_rows [NODES];
	logic [dgr_pkg::NODE_COUNT_W-1:0] vertex_count;

	dgr_pkg::result_t reply_q [$];
	int               mismatches = 0;
	int               snd_idle = 9;
	int               rcv_idle = 88;

	typedef struct packed {
		logic                             cfg_set;
		logic [dgr_pkg::NODE_COUNT_W-1:0] cfg_val;
		logic [1:0]                       kind;
		logic [dgr_pkg::NODE_W-1:0]       src;
		logic [dgr_pkg::NODE_W-1:0]       dst;
		logic                             typed;
		logic [2:0]                       status;
		logic                             found;
	} dir_row_t;

	// typed rows carry the result; others go through the graph model
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{1'b0, 6'd0,  dgr_pkg::KIND_REACH,  5'd0,  5'd0,  1'b1, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_EDGE,   5'd31, 5'd31, 1'b1, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_ADD,    5'd0,  5'd31, 1'b1, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_ADD,    5'd0,  5'd31, 1'b1, dgr_pkg::STATUS_EXISTS, 1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_ADD,    5'd7,  5'd7,  1'b1, dgr_pkg::STATUS_SELF,   1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REMOVE, 5'd3,  5'd4,  1'b1, dgr_pkg::STATUS_ABSENT, 1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_EDGE,   5'd0,  5'd31, 1'b1, dgr_pkg::STATUS_OK,     1'b1},
		'{1'b0, 6'd0,  dgr_pkg::KIND_ADD,    5'd31, 5'd0,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REACH,  5'd0,  5'd0,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REACH,  5'd31, 5'd31, 1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REMOVE, 5'd0,  5'd31, 1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REACH,  5'd31, 5'd31, 1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_ADD,    5'd1,  5'd2,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_ADD,    5'd2,  5'd3,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_ADD,    5'd3,  5'd1,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REACH,  5'd1,  5'd3,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b1, 6'd4,  dgr_pkg::KIND_ADD,    5'd4,  5'd0,  1'b1, dgr_pkg::STATUS_RANGE,  1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REMOVE, 5'd0,  5'd5,  1'b1, dgr_pkg::STATUS_RANGE,  1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REACH,  5'd1,  5'd2,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b1, 6'd3,  dgr_pkg::KIND_REACH,  5'd1,  5'd3,  1'b1, dgr_pkg::STATUS_RANGE,  1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REACH,  5'd2,  5'd1,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b1, 6'd0,  dgr_pkg::KIND_EDGE,   5'd0,  5'd0,  1'b1, dgr_pkg::STATUS_RANGE,  1'b0},
		'{1'b1, 6'd1,  dgr_pkg::KIND_REACH,  5'd0,  5'd0,  1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b1, 6'd63, dgr_pkg::KIND_ADD,    5'd31, 5'd30, 1'b0, dgr_pkg::STATUS_OK,     1'b0},
		'{1'b0, 6'd0,  dgr_pkg::KIND_REACH,  5'd31, 5'd30, 1'b0, dgr_pkg::STATUS_OK,     1'b0}
	};

	int seg_counts [6] = '{32, 9, 63, 20, 32, 6};

	directed_graph_reachability_unit #(
		.MAX_NODES(NODES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int usable_count();
		return (vertex_count > NODES) ? NODES : int'(vertex_count);
	endfunction

	// sweep rows of the growing visited set until it stops growing
	function automatic logic path_exists(input int s, input int d, input int lim);
		logic [NODES-1:0] mask;
		logic [NODES-1:0] seen;
		logic [NODES-1:0] front;
		logic [NODES-1:0] nxt;
		int v;
		int r;
		mask = (lim >= NODES) ? '1 : ((NODES'(1) << lim) - 1'b1);
		front = edge_rows[s] & mask;
		seen = front;
		for (r = 0; r < NODES && front != '0; r++) begin
			nxt = '0;
			for (v = 0; v < lim; v++)
				if (front[v])
					nxt |= edge_rows[v];
			front = nxt & mask & ~seen;
			seen |= front;
		end
		return seen[d];
	endfunction

	function automatic dgr_pkg::result_t graph_answer(input dgr_pkg::item_t it);
		dgr_pkg::result_t r;
		int lim;
		lim = usable_count();
		r.status = dgr_pkg::STATUS_OK;
		r.found = 1'b0;
		if (it.src_node >= lim || it.dst_node >= lim) begin
			r.status = dgr_pkg::STATUS_RANGE;
		end else begin
			case (it.kind)
				dgr_pkg::KIND_ADD: begin
					if (edge_rows[it.src_node][it.dst_node])
						r.status = dgr_pkg::STATUS_EXISTS;
					else if (it.src_node == it.dst_node)
						r.status = dgr_pkg::STATUS_SELF;
					else
						edge_rows[it.src_node][it.dst_node] = 1'b1;
				end
				dgr_pkg::KIND_REMOVE: begin
					if (!edge_rows[it.src_node][it.dst_node])
						r.status = dgr_pkg::STATUS_ABSENT;
					else
						edge_rows[it.src_node][it.dst_node] = 1'b0;
				end
				dgr_pkg::KIND_EDGE: begin
					r.found = edge_rows[it.src_node][it.dst_node];
				end
				default: begin
					r.found = path_exists(it.src_node, it.dst_node, lim);
				end
			endcase
		end
		return r;
	endfunction

	function automatic logic [dgr_pkg::NODE_W-1:0] pick_vertex(input int lim, input int hot);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return dgr_pkg::NODE_W'($urandom_range(0, NODES - 1));
		else if (roll < 55)
			return dgr_pkg::NODE_W'($urandom_range(0, hot - 1));
		else
			return dgr_pkg::NODE_W'($urandom_range(0, lim - 1));
	endfunction

	function automatic dgr_pkg::item_t rand_item(input int lim, input int hot);
		dgr_pkg::item_t it;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			it.kind = dgr_pkg::KIND_ADD;
		else if (roll < 55)
			it.kind = dgr_pkg::KIND_REMOVE;
		else if (roll < 70)
			it.kind = dgr_pkg::KIND_EDGE;
		else
			it.kind = dgr_pkg::KIND_REACH;
		it.src_node = pick_vertex(lim, hot);
		it.dst_node = pick_vertex(lim, hot);
		return it;
	endfunction

	task automatic send_req(input dgr_pkg::item_t it, input logic typed,
	                        input dgr_pkg::result_t given);
		dgr_pkg::result_t pred;
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (in_stall);
		pred = graph_answer(it);
		reply_q.push_back(typed ? given : pred);
	endtask

	// only written with nothing in flight
	task automatic set_count(input logic [dgr_pkg::NODE_COUNT_W-1:0] v);
		in_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		vertex_count = v;
	endtask

	always @(posedge clk) begin
		dgr_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reply_q.size() == 0) begin
				$error("result arrived with no request pending: status %0d found %0d",
					out_item.status, out_item.found);
				mismatches++;
			end else begin
				want = reply_q.pop_front();
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, out_item.status);
					mismatches++;
				end
				if (out_item.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, out_item.found);
					mismatches++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < rcv_idle);
	end

	initial begin
		#(5_000_000);
		$display("directed_graph_reachability_unit verification failed");
		$finish;
	end

	initial begin
		dgr_pkg::item_t it;
		dgr_pkg::result_t given;
		int i;
		int ph;
		int sg;
		int lim;
		int hot;
		for (i = 0; i < NODES; i++)
			edge_rows[i] = '0;
		vertex_count = dgr_pkg::NODE_COUNT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].cfg_set)
				set_count(dir_rows[i].cfg_val);
			it.kind = dir_rows[i].kind;
			it.src_node = dir_rows[i].src;
			it.dst_node = dir_rows[i].dst;
			given.status = dir_rows[i].status;
			given.found = dir_rows[i].found;
			send_req(it, dir_rows[i].typed, given);
		end

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					snd_idle = 9;
					rcv_idle = 88;
				end
				1: begin
					snd_idle = 88;
					rcv_idle = 9;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			for (sg = 0; sg < 2; sg++) begin
				set_count(dgr_pkg::NODE_COUNT_W'(seg_counts[ph * 2 + sg]));
				lim = usable_count();
				// a small cluster of vertices keeps cycles and long paths common
				hot = $urandom_range(3, 12);
				if (hot > lim)
					hot = lim;
				repeat (SEG_ITEMS)
					send_req(rand_item(lim, hot), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("directed_graph_reachability_unit verification clean");
		else
			$display("directed_graph_reachability_unit verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/dgr_pkg.sv
design/dgr_ram.sv
design/dgr_ctrl.sv
design/dgr_datapath.sv
design/directed_graph_reachability_unit.sv
design/dgr_checker.sv
test/tb_directed_graph_reachability_unit.sv
